// File: src/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants of the sha-1 digest engine
// payload structs, round constants, initial hash values, memory geometry
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int WORD_W      = 32;
   localparam int MSG_WORDS   = 16;
   localparam int MSG_AW      = 4;
   localparam int CHAIN_WORDS = 5;
   localparam int CHAIN_AW    = 3;
   localparam int ROUND_W     = 7;

   localparam logic [ROUND_W-1:0] LAST_ROUND  = 7'd79;
   localparam logic [ROUND_W-1:0] LAST_LOADED = 7'd15;
   localparam logic [MSG_AW-1:0]  LEN_HI_WORD = 4'd14;
   localparam logic [MSG_AW-1:0]  LEN_LO_WORD = 4'd15;
   localparam logic [7:0]         PAD_BYTE    = 8'h80;
   localparam logic [5:0]         LAST_BYTE   = 6'd63;

   localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic              digest_last;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] e;
   } work_type;

   // schedule window taps w[t-3], w[t-8], w[t-14], w[t-16]
   typedef struct packed {
      logic [WORD_W-1:0] t3;
      logic [WORD_W-1:0] t8;
      logic [WORD_W-1:0] t14;
      logic [WORD_W-1:0] t16;
   } taps_type;

   function automatic logic [WORD_W-1:0] h_init(input logic [CHAIN_AW-1:0] idx);
      logic [WORD_W-1:0] v;
      case (idx)
         3'd0:    v = 32'h67452301;
         3'd1:    v = 32'hEFCDAB89;
         3'd2:    v = 32'h98BADCFE;
         3'd3:    v = 32'h10325476;
         3'd4:    v = 32'hC3D2E1F0;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: src/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest: byte-serial sha-1 hash engine
// message words in a 16 x 32 ram, chaining words in a 5 x 32 ram, one round
// per cycle, five digest words out on end of message
// ----------------------------------------------------------------------------
//
//   channel   ports                          moves
//   --------  -----------------------------  ------------------------------
//   request   req_valid req_stall req_data   one byte, byte flag, end flag
//   response  rsp_valid rsp_stall rsp_data   one digest word, last flag
//
// a request that does not fill a block or end the message leaves the engine idle
// a request that completes a 64-byte block starts a compression: load the
//   chaining words from their ram, 80 rounds, add back into the ram
// end of message adds the pad word writes, one or two compressions, and a read
//   and a capture state per digest word, held while rsp_stall holds them
// req_stall is high whenever the engine is busy with anything but new bytes
// no clearing pass after reset: valid bits mark chaining entries written
//   since the last digest, the others read as the initial hash values
// ----------------------------------------------------------------------------
module sha1_message_digest (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smd_pkg::rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FIN,
      ST_OUT_RD,
      ST_OUT_CAP
   } state_type;

   // control registers
   state_type                       state_ff, state_in;
   state_type                       ret_ff, ret_in;     // where to go after a compression
   logic [smd_pkg::CHAIN_AW-1:0]    cnt_ff, cnt_in;     // load, add-back and output counter
   logic [smd_pkg::ROUND_W-1:0]     rnd_ff, rnd_in;
   logic [5:0]                      fill_ff, fill_in;   // bytes pending in the block
   logic [63:0]                     bitcnt_ff, bitcnt_in;
   logic [smd_pkg::MSG_AW-1:0]      ptr_ff, ptr_in;     // pad word pointer
   logic                            first_ff, first_in; // next pad word holds the 0x80
   logic                            len_here_ff, len_here_in;
   logic [smd_pkg::CHAIN_WORDS-1:0] h_valid_ff, h_valid_in;
   logic                            hv_sel_ff, hv_sel_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [23:0]                     word_ff, word_in;   // partial word assembly
   smd_pkg::work_type               work_ff, work_in;
   logic [smd_pkg::WORD_W-1:0]      win_ff [smd_pkg::MSG_WORDS];
   logic [smd_pkg::WORD_W-1:0]      win_in [smd_pkg::MSG_WORDS];
   logic [smd_pkg::CHAIN_AW-1:0]    h_rd_addr_ff;
   smd_pkg::rsp_type                rsp_ff, rsp_in;

   // memory ports
   logic                            msg_we;
   logic [smd_pkg::MSG_AW-1:0]      msg_wr_addr;
   logic [smd_pkg::WORD_W-1:0]      msg_wr_data;
   logic [smd_pkg::MSG_AW-1:0]      msg_rd_addr;
   logic [smd_pkg::WORD_W-1:0]      msg_rdata;
   logic                            h_we;
   logic [smd_pkg::CHAIN_AW-1:0]    h_wr_addr;
   logic [smd_pkg::WORD_W-1:0]      h_wr_data;
   logic [smd_pkg::CHAIN_AW-1:0]    h_rd_addr;
   logic [smd_pkg::WORD_W-1:0]      h_rdata;
   logic [smd_pkg::WORD_W-1:0]      h_eff;

   // round datapath
   smd_pkg::taps_type               taps;
   smd_pkg::work_type               round_out;
   logic [smd_pkg::WORD_W-1:0]      sched_word;

   logic                            req_take;
   logic                            rsp_free;
   logic [5:0]                      fill_next;
   logic [smd_pkg::WORD_W-1:0]      pad_word;

   // message buffer, one 32-bit word per entry, big-endian bytes
   smd_ram #(
      .WIDTH (smd_pkg::WORD_W),
      .DEPTH (smd_pkg::MSG_WORDS)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (msg_we),
      .wr_addr (msg_wr_addr),
      .wr_data (msg_wr_data),
      .rd_addr (msg_rd_addr),
      .rd_data (msg_rdata)
   );

   // chaining words h0..h4
   smd_ram #(
      .WIDTH (smd_pkg::WORD_W),
      .DEPTH (smd_pkg::CHAIN_WORDS)
   ) u_chain_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_addr (h_rd_addr),
      .rd_data (h_rdata)
   );

   assign taps.t3  = win_ff[13];
   assign taps.t8  = win_ff[8];
   assign taps.t14 = win_ff[2];
   assign taps.t16 = win_ff[0];

   smd_round u_round (
      .w_in       (work_ff),
      .round_idx  (rnd_ff),
      .msg_word   (msg_rdata),
      .taps       (taps),
      .w_out      (round_out),
      .sched_word (sched_word)
   );

   // entries not written since the last digest read as the initial values
   assign h_eff = hv_sel_ff ? h_rdata : smd_pkg::h_init(h_rd_addr_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fill_next = req_data.byte_valid ? 6'(fill_ff + 6'd1) : fill_ff;

   // first pad word: pending bytes of the partial word, then 0x80, then zeros
   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = {smd_pkg::PAD_BYTE, 24'h0};
         2'd1:    pad_word = {word_ff[7:0], smd_pkg::PAD_BYTE, 16'h0};
         2'd2:    pad_word = {word_ff[15:0], smd_pkg::PAD_BYTE, 8'h0};
         default: pad_word = {word_ff[23:0], smd_pkg::PAD_BYTE};
      endcase
   end

   // memory addressing; chaining ram reads and writes of the same entry never coincide
   always_comb begin
      h_rd_addr = cnt_ff;
      h_we      = (state_ff == ST_FIN) && (cnt_ff != '0);
      h_wr_addr = cnt_ff - 3'd1;
      h_wr_data = h_eff + work_ff.a;
      if (state_ff == ST_ROUND) begin
         msg_rd_addr = rnd_ff[smd_pkg::MSG_AW-1:0] + 4'd1;
      end else begin
         msg_rd_addr = '0;
      end
      hv_sel_in = (h_rd_addr < smd_pkg::CHAIN_AW'(smd_pkg::CHAIN_WORDS)) ?
                  h_valid_ff[h_rd_addr] : 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      fill_in      = fill_ff;
      bitcnt_in    = bitcnt_ff;
      ptr_in       = ptr_ff;
      first_in     = first_ff;
      len_here_in  = len_here_ff;
      h_valid_in   = h_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      word_in      = word_ff;
      work_in      = work_ff;
      win_in       = win_ff;
      rsp_in       = rsp_ff;
      msg_we       = 1'b0;
      msg_wr_addr  = fill_ff[5:2];
      msg_wr_data  = {word_ff, req_data.data_byte};

      if (h_we) begin
         h_valid_in[h_wr_addr] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.byte_valid) begin
                  word_in   = {word_ff[15:0], req_data.data_byte};
                  msg_we    = (fill_ff[1:0] == 2'd3);
                  fill_in   = fill_next;
                  bitcnt_in = bitcnt_ff + 64'd8;
               end
               // pad setup, also used when the block fills first
               ptr_in      = fill_next[5:2];
               first_in    = 1'b1;
               len_here_in = (fill_next[5:2] < smd_pkg::LEN_HI_WORD);
               if (req_data.byte_valid && (fill_ff == smd_pkg::LAST_BYTE)) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  ret_in   = req_data.end_of_message ? ST_PAD : ST_IDLE;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            msg_we      = 1'b1;
            msg_wr_addr = ptr_ff;
            if (first_ff) begin
               msg_wr_data = pad_word;
            end else if (len_here_ff && (ptr_ff == smd_pkg::LEN_HI_WORD)) begin
               msg_wr_data = bitcnt_ff[63:32];
            end else if (len_here_ff && (ptr_ff == smd_pkg::LEN_LO_WORD)) begin
               msg_wr_data = bitcnt_ff[31:0];
            end else begin
               msg_wr_data = '0;
            end
            first_in = 1'b0;
            if (ptr_ff == smd_pkg::LEN_LO_WORD) begin
               // compress; if no length fit, an extra zeros-and-length block follows
               state_in    = ST_LOAD;
               cnt_in      = '0;
               ret_in      = len_here_ff ? ST_OUT_RD : ST_PAD;
               ptr_in      = '0;
               len_here_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + 4'd1;
            end
         end

         ST_LOAD: begin
            // chaining words arrive one a cycle and shift in from e
            if (cnt_ff != '0) begin
               work_in.e = h_eff;
               work_in.d = work_ff.e;
               work_in.c = work_ff.d;
               work_in.b = work_ff.c;
               work_in.a = work_ff.b;
            end
            if (cnt_ff == smd_pkg::CHAIN_AW'(smd_pkg::CHAIN_WORDS)) begin
               state_in = ST_ROUND;
               rnd_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         ST_ROUND: begin
            work_in = round_out;
            for (int i = 0; i < smd_pkg::MSG_WORDS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[smd_pkg::MSG_WORDS-1] = sched_word;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == smd_pkg::LAST_ROUND) begin
               state_in = ST_FIN;
               cnt_in   = '0;
            end
         end

         ST_FIN: begin
            // add a..e into h0..h4, rotating the working words past the adder
            if (cnt_ff != '0) begin
               work_in.a = work_ff.b;
               work_in.b = work_ff.c;
               work_in.c = work_ff.d;
               work_in.d = work_ff.e;
               work_in.e = work_ff.a;
            end
            if (cnt_ff == smd_pkg::CHAIN_AW'(smd_pkg::CHAIN_WORDS)) begin
               state_in = ret_ff;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         ST_OUT_RD: begin
            if (rsp_free) begin
               state_in = ST_OUT_CAP;
            end
         end

         ST_OUT_CAP: begin
            rsp_in.digest_word = h_eff;
            rsp_in.digest_last = (cnt_ff == 3'd4);
            rsp_valid_in       = 1'b1;
            if (cnt_ff == 3'd4) begin
               // back to the initial state for the next message
               state_in   = ST_IDLE;
               cnt_in     = '0;
               fill_in    = '0;
               bitcnt_in  = '0;
               h_valid_in = '0;
            end else begin
               state_in = ST_OUT_RD;
               cnt_in   = cnt_ff + 3'd1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         fill_ff      <= '0;
         bitcnt_ff    <= '0;
         ptr_ff       <= '0;
         first_ff     <= 1'b0;
         len_here_ff  <= 1'b0;
         h_valid_ff   <= '0;
         hv_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         rnd_ff       <= rnd_in;
         fill_ff      <= fill_in;
         bitcnt_ff    <= bitcnt_in;
         ptr_ff       <= ptr_in;
         first_ff     <= first_in;
         len_here_ff  <= len_here_in;
         h_valid_ff   <= h_valid_in;
         hv_sel_ff    <= hv_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff      <= word_in;
      work_ff      <= work_in;
      win_ff       <= win_in;
      h_rd_addr_ff <= h_rd_addr;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // round counter stays within the 80 rounds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff <= smd_pkg::LAST_ROUND))
      else $error("round counter beyond last round");

   // add-back never writes the chaining entry it is reading
   assert property (@(posedge clock) disable iff (reset)
      h_we |-> (h_wr_addr != h_rd_addr))
      else $error("chaining ram read and write collide");

   // message buffer is frozen while a compression reads it
   assert property (@(posedge clock) disable iff (reset)
      msg_we |-> !((state_ff == ST_LOAD) || (state_ff == ST_ROUND)))
      else $error("message ram written during compression");

   // a digest word is only captured into a free response register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_CAP) |-> !rsp_valid_ff)
      else $error("response register overwritten");

   // after the last digest word the engine is back at its initial state
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT_CAP) && (cnt_ff == 3'd4)) |=>
      ((fill_ff == '0) && (bitcnt_ff == '0) && (h_valid_ff == '0)))
      else $error("engine not reinitialized after digest");
`endif

endmodule

// File: src/smd_ram.sv
// ----------------------------------------------------------------------------
// smd_ram: generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module smd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/smd_round.sv
// ----------------------------------------------------------------------------
// smd_round: one sha-1 round
// schedule word selection and the a..e update for round index t
// ----------------------------------------------------------------------------
module smd_round (
   input  smd_pkg::work_type                  w_in,
   input  logic [smd_pkg::ROUND_W-1:0]        round_idx,
   input  logic [smd_pkg::WORD_W-1:0]         msg_word,
   input  smd_pkg::taps_type                  taps,
   output smd_pkg::work_type                  w_out,
   output logic [smd_pkg::WORD_W-1:0]         sched_word
);

   logic [smd_pkg::WORD_W-1:0] mix;
   logic [smd_pkg::WORD_W-1:0] f;
   logic [smd_pkg::WORD_W-1:0] k;
   logic [smd_pkg::WORD_W-1:0] rot_a;

   always_comb begin
      mix = taps.t3 ^ taps.t8 ^ taps.t14 ^ taps.t16;
      // first sixteen rounds take the message words as stored
      if (round_idx <= smd_pkg::LAST_LOADED) begin
         sched_word = msg_word;
      end else begin
         sched_word = {mix[smd_pkg::WORD_W-2:0], mix[smd_pkg::WORD_W-1]};
      end

      if (round_idx < 7'd20) begin
         f = (w_in.b & w_in.c) ^ (~w_in.b & w_in.d);
         k = smd_pkg::K0;
      end else if (round_idx < 7'd40) begin
         f = w_in.b ^ w_in.c ^ w_in.d;
         k = smd_pkg::K1;
      end else if (round_idx < 7'd60) begin
         f = (w_in.b & w_in.c) ^ (w_in.b & w_in.d) ^ (w_in.c & w_in.d);
         k = smd_pkg::K2;
      end else begin
         f = w_in.b ^ w_in.c ^ w_in.d;
         k = smd_pkg::K3;
      end

      rot_a   = {w_in.a[26:0], w_in.a[31:27]};
      w_out.a = rot_a + f + w_in.e + k + sched_word;
      w_out.b = w_in.a;
      w_out.c = {w_in.b[1:0], w_in.b[31:2]};
      w_out.d = w_in.c;
      w_out.e = w_in.d;
   end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the byte-serial sha-1 digest engine
// a short table of directed requests (known digests typed in) followed by
// random messages of mixed lengths; every digest word is checked against the
// typed-in digest or a sha-1 predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // one row of the stimulus plan: the request, plus an optional typed-in digest
   typedef struct packed {
      smd_pkg::req_type  req;
      logic              known;
      logic [0:4][31:0]  want;
   } plan_row_type;

   localparam logic [0:4][31:0] NO_DIGEST  = '0;
   // digest of the empty message
   localparam logic [0:4][31:0] EMPTY_SHA  = {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                              32'h95601890, 32'hafd80709};
   // digest of the three-byte message "abc"
   localparam logic [0:4][31:0] ABC_SHA    = {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                              32'h7850c26c, 32'h9cd0d89d};

   localparam int DIR_ROWS = 13;

   // data, byte flag, end flag, digest known, digest
   localparam plan_row_type DIR_TABLE [DIR_ROWS] = '{
      {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_SHA},   // empty message straight after reset
      {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_SHA},   // empty again: engine re-initialized
      {8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},   // 'a'
      {8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},   // 'b'
      {8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},   // ignored byte inside a message
      {8'h63, 1'b1, 1'b1, 1'b1, ABC_SHA},     // 'c' carrying the end flag
      {8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},   // single all-ones byte with end
      {8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},   // all-zeros byte
      {8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      {8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      {8'h5a, 1'b0, 1'b1, 1'b0, NO_DIGEST},   // end with no byte after data
      {8'ha5, 1'b0, 1'b0, 1'b0, NO_DIGEST},   // ignored byte with nothing pending
      {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_SHA}    // so this is still the empty message
   };

   localparam logic [31:0] SHA_IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   smd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   smd_pkg::rsp_type rsp_data;

   sha1_message_digest u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // sha-1 predictor state
   // ---------------------------------------------------------------------
   logic [7:0]  blk_bytes [64];
   int unsigned blk_fill;
   logic [63:0] msg_bits;
   logic [31:0] chain_h [5];
   logic [31:0] done_h [5];          // digest of the message just finished

   plan_row_type     plan [$];
   smd_pkg::rsp_type digest_fifo [$];      // digest words still to come out

   int          accept_idx;
   int          errors;
   int          cycles;
   int          cycle_limit;
   int          idle_mode;            // 0: no idling, 1: light, 2: heavy
   bit          quiet;                // last part of the run, no idling at all

   function automatic logic [31:0] rol(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void engine_init();
      for (int i = 0; i < 5; i++) chain_h[i] = SHA_IV[i];
      for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
      blk_fill = 0;
      msg_bits = '0;
   endfunction

   // 80-round compression of blk_bytes into chain_h
   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, t, k;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) ^ (~b & d);
            k = smd_pkg::K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = smd_pkg::K1;
         end else if (i < 60) begin
            f = (b & c) ^ (b & d) ^ (c & d);
            k = smd_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = smd_pkg::K3;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   // absorb one request; returns 1 when it finishes a message (digest in done_h)
   function automatic bit hash_step(smd_pkg::req_type r);
      int unsigned idx;
      if (r.byte_valid) begin
         blk_bytes[blk_fill] = r.data_byte;
         blk_fill++;
         msg_bits += 64'd8;
         if (blk_fill == 64) begin
            compress_block();
            blk_fill = 0;
         end
      end
      if (!r.end_of_message) return 1'b0;

      // pad byte, zeros, big-endian bit length; extra block past 55 bytes
      idx = blk_fill;
      blk_bytes[idx] = smd_pkg::PAD_BYTE;
      idx++;
      if (idx > 56) begin
         while (idx < 64) begin
            blk_bytes[idx] = 8'h00;
            idx++;
         end
         compress_block();
         idx = 0;
      end
      while (idx < 56) begin
         blk_bytes[idx] = 8'h00;
         idx++;
      end
      for (int n = 0; n < 8; n++) blk_bytes[56+n] = msg_bits[63-8*n -: 8];
      compress_block();
      for (int n = 0; n < 5; n++) done_h[n] = chain_h[n];
      engine_init();
      return 1'b1;
   endfunction

   function automatic void push_row(logic [7:0] d, logic bv, logic eom);
      plan_row_type r;
      r.req.data_byte      = d;
      r.req.byte_valid     = bv;
      r.req.end_of_message = eom;
      r.known              = 1'b0;
      r.want               = NO_DIGEST;
      plan.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // clock, cycle limit and idling mode
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      // re-roll idling density now and then, mode 0 gives stretches with none
      if (cycles % 64 == 0) idle_mode = $urandom_range(0, 2);
      if (cycle_limit > 0 && cycles > cycle_limit) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic bit take_idle();
      if (quiet || idle_mode == 0) return 1'b0;
      if (idle_mode == 1) return $urandom_range(0, 7) == 0;
      return $urandom_range(0, 2) == 0;
   endfunction

   // ---------------------------------------------------------------------
   // response side: random stall bursts
   // ---------------------------------------------------------------------
   initial begin : drive_rsp_stall
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (take_idle()) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // request side: build the plan, reset, then send every request
   // ---------------------------------------------------------------------
   initial begin : drive_requests
      int n_msgs;
      int len;
      int pause_at;
      int quiet_from;
      bit end_on_byte;
      plan_row_type row;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      idle_mode  = 1;
      engine_init();

      // directed part straight from the table
      for (int i = 0; i < DIR_ROWS; i++) plan.push_back(DIR_TABLE[i]);

      // random messages: often short, many around the one and two block
      // padding boundaries, a few longer than two blocks
      n_msgs   = 0;
      pause_at = -1;
      while (plan.size() < 200) begin
         case ($urandom_range(0, 4))
            0, 1:    len = $urandom_range(0, 12);
            2:       len = $urandom_range(52, 60);
            3:       len = $urandom_range(61, 72);
            default: len = $urandom_range(0, 130);
         endcase
         // last message trimmed so the run stays near 200 requests
         if (len > 200 - plan.size()) len = 200 - plan.size();
         if (n_msgs == 1) pause_at = plan.size();
         end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
         for (int b = 0; b < len; b++) begin
            // occasional ignored byte mixed into the message
            if ($urandom_range(0, 9) == 0) push_row(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_row(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (b == len - 1));
         end
         if (!end_on_byte) begin
            push_row(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end
         n_msgs++;
      end

      quiet_from  = plan.size() * 9 / 10;
      // slowest case per request: full block plus gap, per message: two
      // compressions, padding and stalled digest words; then several times over
      cycle_limit = 4 * (plan.size() * 100 + (n_msgs + DIR_ROWS) * 400) + 2000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < plan.size(); i++) begin
         row   = plan[i];
         quiet = (i >= quiet_from);
         if (i == pause_at) begin
            // hold off until every pending digest word has been taken
            req_valid <= 1'b0;
            @(posedge clock);
            while (digest_fifo.size() != 0) @(posedge clock);
            @(posedge clock);
         end else if (take_idle()) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= row.req;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;

      // drain, then give the engine time to show any stray word
      while (digest_fifo.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      if (errors == 0 && digest_fifo.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // scoreboard: predict on each accepted request, check each accepted word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : score
      smd_pkg::rsp_type got;
      smd_pkg::rsp_type exp_word;
      plan_row_type     row;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            row = plan[accept_idx];
            accept_idx++;
            if (hash_step(req_data)) begin
               // typed-in digest where the row has one, predictor otherwise
               for (int n = 0; n < 5; n++) begin
                  exp_word.digest_word = row.known ? row.want[n] : done_h[n];
                  exp_word.digest_last = (n == 4);
                  digest_fifo.push_back(exp_word);
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (digest_fifo.size() == 0) begin
               if (errors < 10)
                  $display("unexpected digest word %h last %b", got.digest_word,
                           got.digest_last);
               errors++;
            end else begin
               exp_word = digest_fifo.pop_front();
               if (got.digest_word !== exp_word.digest_word ||
                   got.digest_last !== exp_word.digest_last) begin
                  if (errors < 10)
                     $display("digest mismatch: expected %h last %b, got %h last %b",
                              exp_word.digest_word, exp_word.digest_last,
                              got.digest_word, got.digest_last);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// File: files.f
src/smd_pkg.sv
src/smd_ram.sv
src/smd_round.sv
src/sha1_message_digest.sv
verif/tb_top.sv
